@@ hdl/oq_pkg.sv @@
// Shared types, codes and constants for the ordered queue with keyed removal.
package oq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int DEFAULT_ID_BITS     = 16;

   // Fixed field widths of the stream payloads
   localparam int ACTION_W   = 2;
   localparam int PROC_ID_W  = 16;
   localparam int STATUS_W   = 2;
   localparam int REMOVED_W  = 16;
   localparam int COUNT_W    = 5;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [ACTION_W-1:0] {
      ACT_APPEND = 2'd0,
      ACT_POP    = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_NOP    = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       accept;
      logic       append;
      logic       pop_read;
      logic       pop_take;
      logic       scan_first;
      logic       scan_next;
      logic       hit;
      logic       shift;
      logic       drop;
      logic       set_status;
      status_type status;
      logic       load_out;
   } oq_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      action_type action;
      logic       empty;
      logic       full;
      logic       match;
      logic       last;
      logic       out_free;
   } oq_stat_type;

endpackage

@@ hdl/oq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module oq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/oq_ctrl.sv @@
// Controller state machine sequencing append, pop and keyed-removal transactions.
module oq_ctrl
   import oq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  oq_stat_type stat,
   output oq_cmd_type  cmd
);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_DISPATCH = 6'b000010,
      S_POPWAIT  = 6'b000100,
      S_SCAN     = 6'b001000,
      S_SHIFT    = 6'b010000,
      S_FINISH   = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.status = ST_DONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_FINISH;
            unique case (stat.action)
               ACT_APPEND: begin
                  if (stat.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                  end else begin
                     cmd.append = 1'b1;
                  end
               end
               ACT_POP: begin
                  if (stat.empty) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                  end else begin
                     cmd.pop_read = 1'b1;
                     state_in     = S_POPWAIT;
                  end
               end
               ACT_REMOVE: begin
                  if (stat.empty) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                  end else begin
                     cmd.scan_first = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_POPWAIT: begin
            cmd.pop_take = 1'b1;
            state_in     = S_FINISH;
         end
         S_SCAN: begin
            if (stat.match) begin
               cmd.hit  = 1'b1;
               state_in = S_SHIFT;
            end else if (stat.last) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NOT_FOUND;
               state_in       = S_FINISH;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         S_SHIFT: begin
            // close the gap one entry a cycle, then drop the tail
            if (stat.last) begin
               cmd.drop = 1'b1;
               state_in = S_FINISH;
            end else begin
               cmd.shift = 1'b1;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/oq_datapath.sv @@
// Datapath: circular entry store, pointers, count, key compare and result register.
module oq_datapath
   import oq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
   parameter int ID_BITS     = DEFAULT_ID_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  oq_cmd_type            cmd,
   output oq_stat_type           stat
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   action_type          action_ff;
   logic [ID_BITS-1:0]  key_ff;
   status_type          status_ff;
   logic [ID_BITS-1:0]  removed_ff;
   logic [AW-1:0]       head_ff;
   logic [AW-1:0]       cur_ff;
   logic [AW-1:0]       idx_ff;
   logic [CW-1:0]       count_ff;
   logic                rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;

   logic [ID_BITS+PROC_ID_W-1:0] key_wide;
   logic [ID_BITS-1:0]           key_in;
   logic [ID_BITS+REMOVED_W-1:0] removed_wide;
   logic [COUNT_W+CW-1:0]        count_wide;
   logic [AW-1:0]                head_nxt;
   logic [AW-1:0]                cur_nxt;
   logic [AW:0]                  cur_plus2;
   logic [AW-1:0]                cur_nxt2;
   logic [AW:0]                  tail_sum;
   logic [AW-1:0]                tail_addr;
   logic [CW-1:0]                idx_plus1;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [ID_BITS-1:0]  wr_data;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic [ID_BITS-1:0]  rd_data;

   // Fit the 16-bit identifier field to the stored width
   assign key_wide     = {{ID_BITS{1'b0}}, req_tdata[ACTION_W +: PROC_ID_W]};
   assign key_in       = key_wide[ID_BITS-1:0];
   assign removed_wide = {{REMOVED_W{1'b0}}, removed_ff};
   assign count_wide   = {{COUNT_W{1'b0}}, count_ff};

   assign head_nxt  = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + AW'(1);
   assign cur_nxt   = (cur_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : cur_ff + AW'(1);
   assign cur_plus2 = {1'b0, cur_ff} + (AW+1)'(2);
   assign cur_nxt2  = (cur_plus2 >= (AW+1)'(QUEUE_DEPTH)) ?
                      AW'(cur_plus2 - (AW+1)'(QUEUE_DEPTH)) : AW'(cur_plus2);
   assign tail_sum  = {1'b0, head_ff} + (AW+1)'(count_ff);
   assign tail_addr = (tail_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                      AW'(tail_sum - (AW+1)'(QUEUE_DEPTH)) : AW'(tail_sum);
   assign idx_plus1 = CW'(idx_ff) + CW'(1);

   // Store port selection
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = tail_addr;
      wr_data = key_ff;
      rd_en   = 1'b0;
      rd_addr = cur_nxt;
      if (cmd.append) begin
         wr_en = 1'b1;
      end
      if (cmd.shift) begin
         wr_en   = 1'b1;
         wr_addr = cur_ff;
         wr_data = rd_data;
         rd_en   = 1'b1;
         rd_addr = cur_nxt2;
      end
      if (cmd.pop_read) begin
         rd_en   = 1'b1;
         rd_addr = head_ff;
      end
      if (cmd.scan_first) begin
         rd_en   = 1'b1;
         rd_addr = cur_ff;
      end
      if (cmd.scan_next || cmd.hit) begin
         rd_en   = 1'b1;
         rd_addr = cur_nxt;
      end
   end

   oq_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (cmd.append) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.pop_take) begin
            head_ff  <= head_nxt;
            count_ff <= count_ff - CW'(1);
         end
         if (cmd.drop) begin
            count_ff <= count_ff - CW'(1);
         end
         if (cmd.load_out) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // Per-transaction payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         action_ff  <= action_type'(req_tdata[ACTION_W-1:0]);
         key_ff     <= key_in;
         status_ff  <= ST_DONE;
         removed_ff <= '0;
         cur_ff     <= head_ff;
         idx_ff     <= '0;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.pop_take || cmd.hit) begin
         removed_ff <= rd_data;
      end
      if (cmd.scan_next || cmd.shift) begin
         cur_ff <= cur_nxt;
         idx_ff <= idx_ff + AW'(1);
      end
      if (cmd.load_out) begin
         rsp_tdata_ff <= {{(RSP_DATA_W - STATUS_W - REMOVED_W - COUNT_W){1'b0}},
                          count_wide[COUNT_W-1:0],
                          removed_wide[REMOVED_W-1:0],
                          status_ff};
      end
   end

   assign stat.action   = action_ff;
   assign stat.empty    = (count_ff == '0);
   assign stat.full     = (count_ff == CW'(QUEUE_DEPTH));
   assign stat.match    = (rd_data == key_ff);
   assign stat.last     = (idx_plus1 == count_ff);
   assign stat.out_free = !rsp_tvalid_ff || rsp_tready;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

@@ hdl/ordered_queue_with_keyed_removal_top.sv @@
// Top level of the ordered queue of identifiers with removal by key.
//
// Requests arrive on the req_ stream: tdata[1:0] is the action (append, pop,
// remove by id, or no operation) and tdata[17:2] the identifier. Each request
// gives one result on the rsp_ stream: tdata[1:0] status, tdata[17:2] the
// removed identifier (zero unless a pop or removal succeeded), tdata[22:18] the
// entry count afterwards. Entries live in a circular RAM with a head pointer.
// One request is worked at a time. An append writes at the tail; a pop reads
// the head entry and then takes it; a remove by id scans the entries one per
// cycle until a match or the last one, then closes the gap one entry per cycle
// through the single RAM read and write port. req_tready returns the cycle
// after the result is loaded, so the next request overlaps with the wait for
// rsp_tready: a stalled result sits in the output register while the next
// request is already taken and worked, and only its own result waits.
// Reset empties the queue and drops any pending result; entry contents need
// no clearing.
module ordered_queue_with_keyed_removal_top
   import oq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
   parameter int ID_BITS     = DEFAULT_ID_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // action[1:0], proc_id[17:2]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // status[1:0], removed_id[17:2],
                                             // entry_count[22:18]
);

   oq_cmd_type  cmd;
   oq_stat_type stat;

   oq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   oq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

   // Never write past a full queue
   assert property (@(posedge clock) disable iff (reset) cmd.append |-> !stat.full)
      else $error("append issued on a full queue");

   // Never drop an entry from an empty queue
   assert property (@(posedge clock) disable iff (reset) cmd.drop |-> !stat.empty)
      else $error("drop issued on an empty queue");

   // Never overwrite a result that has not been taken
   assert property (@(posedge clock) disable iff (reset) cmd.load_out |-> stat.out_free)
      else $error("result register overwritten");

   // One transaction in work at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in work");

endmodule
